FILE: sv/htwd_pkg.sv
package htwd_pkg;

	localparam int NODE_W        = 9;
	localparam int NODE_AW       = 8;
	localparam int BITS_PER_BYTE = 8;
	localparam int BIT_CNT_W     = 3;
	localparam int CNT_W         = 32;

	localparam logic [NODE_W-1:0] ROOT_RESET = 9'd256;

	localparam logic [1:0] MODE_LOAD    = 2'd0;
	localparam logic [1:0] MODE_DATA    = 2'd1;
	localparam logic [1:0] MODE_RESTART = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_FLUSH
	} htwd_state_t;

	typedef struct packed {
		logic load;
		logic restart;
		logic start;
		logic step;
		logic flush;
	} htwd_cmd_t;

	typedef struct packed {
		logic stall;
		logic walk_end;
		logic flush_ok;
		logic finished;
	} htwd_stat_t;

endpackage

FILE: sv/htwd_ctrl.sv
module htwd_ctrl import htwd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [1:0] mode,
	input  htwd_stat_t stat,
	output htwd_cmd_t  cmd
);

	htwd_state_t state_q;
	htwd_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					unique case (mode)
						MODE_LOAD: begin
							cmd.load = 1'b1;
						end
						MODE_DATA: begin
							// drop data bytes once the symbol total was reached
							if (!stat.finished) begin
								cmd.start = 1'b1;
								state_d   = ST_WALK;
							end
						end
						MODE_RESTART: begin
							cmd.restart = 1'b1;
						end
						default: begin
						end
					endcase
				end
			end
			ST_WALK: begin
				if (!stat.stall) begin
					cmd.step = 1'b1;
					if (stat.walk_end) begin
						state_d = ST_FLUSH;
					end
				end
			end
			ST_FLUSH: begin
				if (stat.flush_ok) begin
					cmd.flush = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

FILE: sv/htwd_datapath.sv
module htwd_datapath import htwd_pkg::*; #(
	parameter int LEAF_COUNT = 256
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  htwd_cmd_t                cmd,
	input  logic [NODE_W-1:0]        node_index,
	input  logic [NODE_W-1:0]        left_child,
	input  logic [NODE_W-1:0]        right_child,
	input  logic [BITS_PER_BYTE-1:0] data_byte,
	input  logic [NODE_W-1:0]        root_index,
	input  logic [CNT_W-1:0]         total_symbols,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [7:0]               symbol,
	output logic                     last_of_run,
	output logic                     stream_done,
	output htwd_stat_t               stat
);

	localparam logic [NODE_W-1:0]    LeafLimit = NODE_W'(LEAF_COUNT);
	localparam logic [BIT_CNT_W-1:0] LastBit   = BIT_CNT_W'(BITS_PER_BYTE - 1);

	logic [2*NODE_W-1:0]      mem [2**NODE_AW];
	logic [2*NODE_W-1:0]      rd_q;
	logic [NODE_AW-1:0]       rd_addr;
	logic                     rd_en;

	logic [NODE_W-1:0]        walk_q;
	logic [BITS_PER_BYTE-1:0] byte_q;
	logic [BIT_CNT_W-1:0]     bit_cnt_q;
	logic [CNT_W-1:0]         cnt_q;
	logic                     finished_q;

	logic                     pend_valid_q;
	logic [7:0]               pend_sym_q;
	logic                     pend_done_q;

	logic                     out_valid_q;
	logic [7:0]               out_sym_q;
	logic                     out_last_q;
	logic                     out_done_q;

	logic [NODE_W-1:0]        child;
	logic                     leaf;
	logic [NODE_W-1:0]        next_pos;
	logic [CNT_W-1:0]         cnt_inc;
	logic                     hit_total;
	logic                     slot_free;
	logic                     push;

	// rd_q holds the entry of the current node; the next address follows from it
	assign child     = byte_q[BITS_PER_BYTE-1] ? rd_q[NODE_W-1:0] : rd_q[2*NODE_W-1:NODE_W];
	assign leaf      = (child < LeafLimit);
	assign next_pos  = leaf ? root_index : child;
	assign cnt_inc   = cnt_q + CNT_W'(1);
	assign hit_total = (total_symbols != '0) && (cnt_inc == total_symbols);
	assign slot_free = !out_valid_q || out_ready;
	assign push      = pend_valid_q && ((cmd.step && leaf) || cmd.flush);

	assign rd_en   = cmd.start || cmd.step;
	assign rd_addr = cmd.start ? walk_q[NODE_AW-1:0] : next_pos[NODE_AW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mem[node_index[NODE_AW-1:0]] <= {left_child, right_child};
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_q       <= ROOT_RESET;
			bit_cnt_q    <= '0;
			cnt_q        <= '0;
			finished_q   <= 1'b0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.restart) begin
				walk_q     <= root_index;
				cnt_q      <= '0;
				finished_q <= 1'b0;
			end
			if (cmd.start) begin
				bit_cnt_q <= '0;
			end
			if (cmd.step) begin
				walk_q    <= next_pos;
				bit_cnt_q <= bit_cnt_q + BIT_CNT_W'(1);
				if (leaf) begin
					cnt_q        <= cnt_inc;
					pend_valid_q <= 1'b1;
					if (hit_total) begin
						finished_q <= 1'b1;
					end
				end
			end
			if (cmd.flush) begin
				pend_valid_q <= 1'b0;
			end
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			byte_q <= data_byte;
		end else if (cmd.step) begin
			byte_q <= {byte_q[BITS_PER_BYTE-2:0], 1'b0};
		end
		if (cmd.step && leaf) begin
			pend_sym_q  <= child[7:0];
			pend_done_q <= hit_total;
		end
		if (push) begin
			out_sym_q  <= pend_sym_q;
			out_last_q <= cmd.flush;
			out_done_q <= pend_done_q;
		end
	end

	assign stat.stall    = leaf && pend_valid_q && !slot_free;
	assign stat.walk_end = (bit_cnt_q == LastBit) || (leaf && hit_total);
	assign stat.flush_ok = !pend_valid_q || slot_free;
	assign stat.finished = finished_q;

	assign out_valid   = out_valid_q;
	assign symbol      = out_sym_q;
	assign last_of_run = out_last_q;
	assign stream_done = out_done_q;

`ifndef SYNTHESIS
	a_push_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> slot_free)
		else $error("symbol pushed over an untaken output");

	a_no_start_finished: assert property (@(posedge clk) disable iff (!arst_n)
		finished_q |-> !cmd.start)
		else $error("data byte walked after symbol total reached");

	a_no_step_past_done: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_valid_q && pend_done_q) |-> !cmd.step)
		else $error("walk continued past the final symbol");

	a_flush_follows_done: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && leaf && hit_total) |=> !cmd.step)
		else $error("walk did not end on reaching the symbol total");
`endif

endmodule

FILE: sv/huffman_tree_walk_decoder_top.sv
// Huffman tree-walk decoder. Load the code tree with mode 0 transfers (one internal node
// each), send mode 2 to start a stream at root_index, then send compressed bytes as mode 1
// transfers; each byte yields zero to eight symbols, the last one flagged on tlast and the
// one that reaches total_symbols flagged on tuser. A data byte occupies the block from the
// accept cycle through up to eight walk steps (one node memory lookup per bit, the next
// read address taken straight from the previous registered read) and the hand-off of the
// held last symbol; a stalled output holds both. Load and restart transfers leave
// the block idle. Reading a node that was never loaded gives undefined symbols.
module huffman_tree_walk_decoder_top import htwd_pkg::*; #(
	parameter int LEAF_COUNT = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// node_index[8:0], left_child[17:9], right_child[26:18], data_byte[34:27], zero fill
	input  logic [39:0] s_tdata,
	// mode[1:0]
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// symbol[7:0]
	output logic [7:0]  m_tdata,
	output logic        m_tlast,
	// stream_done[0]
	output logic [0:0]  m_tuser,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [NODE_W-1:0] root_q;
	logic [CNT_W-1:0]  total_q;
	logic              cfg_wr;
	htwd_cmd_t         cmd;
	htwd_stat_t        stat;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	// register 0 at byte 0, register 1 at byte 4
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_q  <= ROOT_RESET;
			total_q <= '0;
		end else if (cfg_wr) begin
			if (paddr[2]) begin
				total_q <= pwdata;
			end else begin
				root_q <= pwdata[NODE_W-1:0];
			end
		end
	end

	assign prdata = paddr[2] ? total_q : {{(32-NODE_W){1'b0}}, root_q};

	htwd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.mode     (s_tuser),
		.stat     (stat),
		.cmd      (cmd)
	);

	htwd_datapath #(
		.LEAF_COUNT (LEAF_COUNT)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.node_index    (s_tdata[8:0]),
		.left_child    (s_tdata[17:9]),
		.right_child   (s_tdata[26:18]),
		.data_byte     (s_tdata[34:27]),
		.root_index    (root_q),
		.total_symbols (total_q),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.symbol        (m_tdata),
		.last_of_run   (m_tlast),
		.stream_done   (m_tuser[0]),
		.stat          (stat)
	);

endmodule

FILE: bench/tb_huffman_tree_walk_decoder_top.sv
`timescale 1ns / 100ps

module tb_huffman_tree_walk_decoder_top;
	import htwd_pkg::*;

	localparam int          LEAF_COUNT   = 256;
	localparam logic [1:0]  MODE_IGNORED = 2'd3;
	localparam logic [2:0]  REG_ROOT     = 3'd0;
	localparam logic [2:0]  REG_TOTAL    = 3'd4;
	localparam int          IDLE_CYCLES  = 24;
	localparam int          DRAIN_LIMIT  = 50000;
	localparam int          TREE_ROUNDS  = 6;

	typedef struct packed {
		logic [7:0] symbol;
		logic       last;
		logic       done;
	} sym_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata  = '0;
	logic [1:0]  s_tuser  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        m_tlast;
	logic [0:0]  m_tuser;
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [2:0]  paddr    = '0;
	logic [31:0] pwdata   = '0;
	logic [31:0] prdata;
	logic        pready;

	// decoder state as predicted from the accepted transfers
	logic [17:0] tree_mem [256];
	logic [8:0]  cur_node    = ROOT_RESET;
	logic [31:0] sym_count   = '0;
	bit          stream_over = 1'b0;
	logic [8:0]  root_reg    = ROOT_RESET;
	logic [31:0] limit_reg   = '0;

	sym_t        pending_symbols[$];
	logic [8:0]  tree_nodes[$];

	bit quiet    = 1'b0;
	int hold_req = 0;
	int mismatch_cnt, symbols_seen, load_cnt, data_cnt, restart_cnt, trees_built;

	huffman_tree_walk_decoder_top #(.LEAF_COUNT(LEAF_COUNT)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.prdata(prdata), .pready(pready)
	);

	always #5 clk = ~clk;

	initial begin
		#20ms;
		$display("Simulation FAILED");
		$finish;
	end

	function automatic int gap_len();
		if ($urandom_range(0, 15) == 0) return $urandom_range(20, 60);
		return $urandom_range(1, 3);
	endfunction

	task automatic report_mismatch(input string msg);
		mismatch_cnt++;
		if (mismatch_cnt <= 10) $display("%t: %s", $realtime, msg);
	endtask

	task automatic predict_symbols(input logic [1:0] mode, input logic [8:0] idx,
			input logic [8:0] lc, input logic [8:0] rc, input logic [7:0] code_byte);
		logic [17:0] entry;
		logic [8:0]  nxt;
		sym_t        res;
		int          i;
		int          produced;
		produced = 0;
		case (mode)
			MODE_LOAD: begin
				tree_mem[idx[7:0]] = {lc, rc};
				load_cnt++;
			end
			MODE_RESTART: begin
				cur_node    = root_reg;
				sym_count   = '0;
				stream_over = 1'b0;
				restart_cnt++;
			end
			MODE_DATA: begin
				data_cnt++;
				for (i = BITS_PER_BYTE - 1; i >= 0 && !stream_over; i--) begin
					entry = tree_mem[cur_node[7:0]];
					nxt   = code_byte[i] ? entry[8:0] : entry[17:9];
					if (nxt < LEAF_COUNT) begin
						sym_count  = sym_count + 1;
						res.symbol = nxt[7:0];
						res.last   = 1'b0;
						res.done   = (limit_reg != 0) && (sym_count == limit_reg);
						pending_symbols.push_back(res);
						produced++;
						cur_node = root_reg;
						if (res.done) stream_over = 1'b1;
					end else begin
						cur_node = nxt;
					end
				end
				if (produced > 0) pending_symbols[pending_symbols.size() - 1].last = 1'b1;
			end
			default: ;
		endcase
	endtask

	// leave tvalid high after the transfer so back-to-back items need no deassertion in between
	task automatic send_item(input logic [1:0] mode, input logic [8:0] idx,
			input logic [8:0] lc, input logic [8:0] rc, input logic [7:0] code_byte);
		int gap;
		gap = (!quiet && $urandom_range(0, 3) == 0) ? gap_len() : 0;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= {5'd0, code_byte, rc, lc, idx};
		do @(posedge clk); while (!s_tready);
		predict_symbols(mode, idx, lc, rc, code_byte);
	endtask

	task automatic send_plain(input logic [1:0] mode, input logic [7:0] code_byte);
		send_item(mode, 9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)),
			9'($urandom_range(0, 511)), code_byte);
	endtask

	task automatic wait_idle();
		int n;
		s_tvalid <= 1'b0;
		n = 0;
		while (pending_symbols.size() != 0 && n < DRAIN_LIMIT) begin
			@(posedge clk);
			n++;
		end
		if (pending_symbols.size() != 0) begin
			report_mismatch($sformatf("%0d expected symbols never arrived",
				pending_symbols.size()));
			mismatch_cnt += pending_symbols.size() - 1;
			pending_symbols.delete();
		end
		repeat (IDLE_CYCLES) @(posedge clk);
	endtask

	task automatic reg_read(input logic [2:0] addr, input logic [31:0] exp_val);
		@(posedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b0;
		penable <= 1'b0;
		paddr   <= addr;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== exp_val)
			report_mismatch($sformatf("register %0d read: expected %h got %h",
				addr, exp_val, prdata));
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic cfg_write(input logic [2:0] addr, input logic [31:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= addr;
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (addr == REG_ROOT) root_reg = val[8:0];
		else limit_reg = val;
		psel    <= 1'b0;
		penable <= 1'b0;
		reg_read(addr, val);
	endtask

	task automatic test_register_reset();
		reg_read(REG_ROOT, {23'd0, ROOT_RESET});
		reg_read(REG_TOTAL, 32'd0);
	endtask

	// small tree: "1" -> 0, "00" -> 255, "011" -> 128, "010" loops back to the root
	task automatic test_basic_walk();
		send_item(MODE_LOAD, 9'd256, 9'd511, 9'd0, 8'h00);
		send_item(MODE_LOAD, 9'd511, 9'd255, 9'd257, 8'hFF);
		send_item(MODE_LOAD, 9'd257, 9'd256, 9'd128, 8'h5A);
		wait_idle();
		cfg_write(REG_ROOT, 32'd256);
		cfg_write(REG_TOTAL, 32'd0);
		send_plain(MODE_RESTART, 8'h00);
		send_plain(MODE_DATA, 8'h00);
		send_plain(MODE_DATA, 8'hFF);
		send_plain(MODE_DATA, 8'hA5);
		send_plain(MODE_IGNORED, 8'hFF);
		// ends partway through a code, leaving the walk at node 511
		send_plain(MODE_DATA, 8'h60);
	endtask

	task automatic test_root_change();
		wait_idle();
		// the walk under way must finish from where it stands
		cfg_write(REG_ROOT, 32'd257);
		send_plain(MODE_DATA, 8'h4E);
		// node number below 256 lands on the same entry as 257
		send_item(MODE_LOAD, 9'h001, 9'd1, 9'd511, 8'h33);
		send_plain(MODE_DATA, 8'hC3);
		wait_idle();
		cfg_write(REG_ROOT, 32'd0);
		send_plain(MODE_RESTART, 8'h11);
		send_plain(MODE_DATA, 8'h96);
	endtask

	task automatic test_symbol_limit();
		wait_idle();
		cfg_write(REG_TOTAL, 32'd3);
		send_plain(MODE_RESTART, 8'h00);
		send_plain(MODE_DATA, 8'hFF);
		send_plain(MODE_DATA, 8'h00);
		send_plain(MODE_RESTART, 8'h00);
		send_plain(MODE_DATA, 8'h00);
		wait_idle();
		cfg_write(REG_TOTAL, 32'hFFFF_FFFF);
		send_plain(MODE_RESTART, 8'h00);
		send_plain(MODE_DATA, 8'h3C);
	endtask

	// every bit yields a symbol; the receiver holds off so the block backs up
	task automatic test_backpressure();
		int n;
		wait_idle();
		send_item(MODE_LOAD, 9'd300, 9'd60, 9'd195, 8'h00);
		wait_idle();
		cfg_write(REG_ROOT, 32'd300);
		cfg_write(REG_TOTAL, 32'd0);
		send_plain(MODE_RESTART, 8'h00);
		quiet    = 1'b1;
		hold_req = 300;
		for (n = 0; n < 30; n++) send_plain(MODE_DATA, 8'($urandom_range(0, 255)));
		wait_idle();
		quiet = 1'b0;
	endtask

	// load a random tree in breadth-first order; every child that is not a leaf is loaded
	task automatic build_tree(input int node_cnt);
		bit         taken[256];
		logic [8:0] cand, lc, rc;
		int         nxt, j;
		tree_nodes.delete();
		while (tree_nodes.size() < node_cnt) begin
			cand = 9'h100 | 9'($urandom_range(0, 255));
			if (!taken[cand[7:0]]) begin
				taken[cand[7:0]] = 1'b1;
				tree_nodes.push_back(cand);
			end
		end
		nxt = 1;
		for (j = 0; j < node_cnt; j++) begin
			if (nxt < node_cnt && $urandom_range(0, 1)) begin
				lc = tree_nodes[nxt];
				nxt++;
			end else if ($urandom_range(0, 9) == 0) begin
				lc = tree_nodes[$urandom_range(0, nxt - 1)];
			end else begin
				lc = 9'($urandom_range(0, 255));
			end
			if (nxt < node_cnt && ($urandom_range(0, 1) || nxt == j + 1)) begin
				rc = tree_nodes[nxt];
				nxt++;
			end else begin
				rc = 9'($urandom_range(0, 255));
			end
			send_item(MODE_LOAD, tree_nodes[j], lc, rc, 8'($urandom_range(0, 255)));
		end
		trees_built++;
	endtask

	function automatic logic [31:0] pick_total();
		case ($urandom_range(0, 4))
			0: return 32'd0;
			1: return $urandom_range(1, 40);
			2: return 32'hFFFF_FFFF;
			3: return $urandom;
			default: return $urandom_range(80, 200);
		endcase
	endfunction

	task automatic reload_node();
		logic [8:0] tgt, lc, rc;
		tgt = tree_nodes[$urandom_range(0, tree_nodes.size() - 1)];
		if ($urandom_range(0, 1)) tgt[8] = 1'b0;
		lc = 9'($urandom_range(0, 255));
		rc = 9'($urandom_range(0, 255));
		// keep a leaf on one side so the walk can always get out
		case ($urandom_range(0, 2))
			1: lc = tree_nodes[$urandom_range(0, tree_nodes.size() - 1)];
			2: rc = tree_nodes[$urandom_range(0, tree_nodes.size() - 1)];
			default: ;
		endcase
		send_item(MODE_LOAD, tgt, lc, rc, 8'($urandom_range(0, 255)));
	endtask

	task automatic test_random_trees();
		int t, counted, pick;
		bit moved;
		for (t = 0; t < TREE_ROUNDS; t++) begin
			wait_idle();
			build_tree((t == TREE_ROUNDS - 1) ? $urandom_range(60, 100) : $urandom_range(2, 16));
			wait_idle();
			cfg_write(REG_ROOT, {23'd0, tree_nodes[0]});
			cfg_write(REG_TOTAL, pick_total());
			send_plain(MODE_RESTART, 8'($urandom_range(0, 255)));
			counted = 0;
			moved   = 1'b0;
			while (counted < 45) begin
				if (counted == 22 && !moved) begin
					moved = 1'b1;
					wait_idle();
					cfg_write(REG_ROOT,
						{23'd0, tree_nodes[$urandom_range(0, tree_nodes.size() - 1)]});
				end
				pick = $urandom_range(0, 99);
				if (pick < 3 || (stream_over && pick < 40)) begin
					send_plain(MODE_RESTART, 8'($urandom_range(0, 255)));
					counted++;
				end else if (pick < 6) begin
					send_plain(MODE_IGNORED, 8'($urandom_range(0, 255)));
				end else if (pick < 10) begin
					reload_node();
					counted++;
				end else begin
					if (!stream_over) counted++;
					send_plain(MODE_DATA, 8'($urandom_range(0, 255)));
				end
			end
		end
	endtask

	// receiver: random short and long stalls, plus an occasional long hold-off
	initial begin
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req != 0) begin
				stall_left = hold_req;
				hold_req   = 0;
			end else if (stall_left == 0 && !quiet && $urandom_range(0, 4) == 0) begin
				stall_left = gap_len();
			end
			m_tready <= (stall_left == 0);
			if (stall_left != 0) stall_left--;
		end
	end

	always @(posedge clk) begin
		sym_t exp_sym;
		if (arst_n && m_tvalid && m_tready) begin
			symbols_seen++;
			if (pending_symbols.size() == 0) begin
				report_mismatch($sformatf("unexpected symbol %0d last %0b done %0b",
					m_tdata, m_tlast, m_tuser[0]));
			end else begin
				exp_sym = pending_symbols.pop_front();
				if (m_tdata !== exp_sym.symbol || m_tlast !== exp_sym.last ||
						m_tuser[0] !== exp_sym.done)
					report_mismatch($sformatf(
						"symbol: expected %0d last %0b done %0b, got %0d last %0b done %0b",
						exp_sym.symbol, exp_sym.last, exp_sym.done,
						m_tdata, m_tlast, m_tuser[0]));
			end
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		test_register_reset();
		test_basic_walk();
		test_root_change();
		test_symbol_limit();
		test_backpressure();
		test_random_trees();
		wait_idle();
		$display("Decoded %0d symbols from %0d data bytes over %0d random trees,",
			symbols_seen, data_cnt, trees_built);
		$display("with %0d node loads, %0d restarts, symbol limits and root moves.",
			load_cnt, restart_cnt);
		if (mismatch_cnt == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d mismatches", mismatch_cnt);
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
